// File: sv/tec_pkg.sv
// ----------------------------------------------------------------------------
// tec_pkg
// shared constants and types of the terminal echo canceller
// ----------------------------------------------------------------------------
`default_nettype none

package tec_pkg;

	localparam int ECHO_DEPTH = 4096;
	localparam int AW = $clog2(ECHO_DEPTH);
	localparam int CW = $clog2(ECHO_DEPTH + 1);
	localparam int PW = CW + 1;
	localparam int LW = ((CW > 16) ? CW : 16) + 1;
	localparam int QDEPTH = 2;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_SP = 8'h20;

	localparam logic MODE_RECORD = 1'b0;
	localparam logic MODE_RECEIVE = 1'b1;

	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_BS,
		HOLD_BS_SP
	} hold_t;

	typedef struct packed {
		logic mode;
		logic [7:0] data;
		logic last;
		logic is_bs;
		logic is_sp;
		logic is_cr;
		logic len_over;
		logic [CW-1:0] len_c;
	} entry_t;

endpackage

`default_nettype wire

// File: sv/tec_front.sv
// ----------------------------------------------------------------------------
// tec_front
// accepts requests, decodes byte classes and chunk length, queues them
// ----------------------------------------------------------------------------
`default_nettype none

module tec_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // data_byte[7:0], chunk_length[23:8]
	input  wire logic s_axis_tuser,         // mode
	input  wire logic s_axis_tlast,
	output logic e_valid,
	output tec_pkg::entry_t e,
	input  wire logic e_pop
);

	tec_pkg::entry_t q_q [tec_pkg::QDEPTH];
	logic [tec_pkg::QAW-1:0] wp_q;
	logic [tec_pkg::QAW-1:0] rp_q;
	logic [tec_pkg::QAW:0] cnt_q;
	tec_pkg::entry_t dec;
	logic [tec_pkg::LW-1:0] len_x;
	logic push;

	always_comb begin
		len_x = tec_pkg::LW'(s_axis_tdata[23:8]);
		dec.mode = s_axis_tuser;
		dec.data = s_axis_tdata[7:0];
		dec.last = s_axis_tlast;
		dec.is_bs = (s_axis_tdata[7:0] == tec_pkg::CH_BS);
		dec.is_sp = (s_axis_tdata[7:0] == tec_pkg::CH_SP);
		dec.is_cr = (s_axis_tdata[7:0] == tec_pkg::CH_CR);
		dec.len_over = (len_x > tec_pkg::LW'(tec_pkg::ECHO_DEPTH));
		dec.len_c = dec.len_over ? tec_pkg::CW'(tec_pkg::ECHO_DEPTH) : tec_pkg::CW'(len_x);
	end

	assign s_axis_tready = (cnt_q != (tec_pkg::QAW + 1)'(tec_pkg::QDEPTH));
	assign push = s_axis_tvalid && s_axis_tready;
	assign e_valid = (cnt_q != '0);
	assign e = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (e_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !e_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && e_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/tec_back.sv
// ----------------------------------------------------------------------------
// tec_back
// expected-echo fifo, echo matching and result register
// ----------------------------------------------------------------------------
`default_nettype none

module tec_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic e_valid,
	input  wire tec_pkg::entry_t e,
	output logic e_pop,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [7:0] m_axis_tdata,  // out_byte
	output logic m_axis_tuser,        // byte_valid
	output logic m_axis_tlast         // chunk_end
);

	logic [7:0] mem [tec_pkg::ECHO_DEPTH];
	logic [7:0] rd_q;
	logic byp_q;
	logic [7:0] bypd_q;
	logic [7:0] head;

	logic [tec_pkg::AW-1:0] rp_q, rp_n, rd_addr;
	logic [tec_pkg::CW-1:0] fill_q, fill_n;
	logic pass_q, pass_n;
	logic inrec_q, inrec_n;
	logic drop_q, drop_n;
	tec_pkg::hold_t hold_q, hold_n;
	logic phase_q, phase_n;

	logic we;
	logic [tec_pkg::AW-1:0] waddr;
	logic emit, bv, ce, done, do_match, ml, m_cr, m_bs, advance, out_free;
	logic [7:0] ob, mb;
	logic [tec_pkg::PW-1:0] pos;
	logic [tec_pkg::PW-1:0] sum;
	logic [tec_pkg::AW:0] rp_inc;

	assign head = byp_q ? bypd_q : rd_q;

	always_comb begin
		rp_n = rp_q;
		fill_n = fill_q;
		pass_n = pass_q;
		inrec_n = inrec_q;
		drop_n = drop_q;
		hold_n = hold_q;
		phase_n = phase_q;
		we = 1'b0;
		waddr = '0;
		emit = 1'b0;
		ob = '0;
		bv = 1'b0;
		ce = 1'b0;
		done = 1'b1;
		do_match = 1'b0;
		mb = e.data;
		ml = e.last;
		m_cr = e.is_cr;
		m_bs = e.is_bs;
		pos = '0;
		sum = tec_pkg::PW'(fill_q) + tec_pkg::PW'(e.len_c);
		rp_inc = (tec_pkg::AW + 1)'(rp_q) + 1'b1;
		if (e.mode == tec_pkg::MODE_RECORD) begin
			if (!inrec_q) begin
				if (sum > tec_pkg::PW'(tec_pkg::ECHO_DEPTH)) begin
					rp_n = '0;
					fill_n = '0;
				end
				drop_n = e.len_over;
			end
			if (!drop_n && (fill_n < tec_pkg::CW'(tec_pkg::ECHO_DEPTH))) begin
				pos = tec_pkg::PW'(rp_n) + tec_pkg::PW'(fill_n);
				if (pos >= tec_pkg::PW'(tec_pkg::ECHO_DEPTH)) begin
					pos = pos - tec_pkg::PW'(tec_pkg::ECHO_DEPTH);
				end
				we = 1'b1;
				waddr = pos[tec_pkg::AW-1:0];
				fill_n = fill_n + 1'b1;
			end
			inrec_n = !e.last;
			if (e.last) begin
				drop_n = 1'b0;
			end
		end else begin
			case (hold_q)
				tec_pkg::HOLD_BS: begin
					hold_n = tec_pkg::HOLD_NONE;
					if (e.is_sp && !e.last) begin
						hold_n = tec_pkg::HOLD_BS_SP;
					end else begin
						do_match = 1'b1;
					end
				end
				tec_pkg::HOLD_BS_SP: begin
					if (e.is_bs) begin
						hold_n = tec_pkg::HOLD_NONE;
					end else if (!phase_q) begin
						// held space matched first, entry stays for a second pass
						mb = tec_pkg::CH_SP;
						ml = 1'b0;
						m_cr = 1'b0;
						m_bs = 1'b0;
						do_match = 1'b1;
						done = 1'b0;
						phase_n = 1'b1;
					end else begin
						hold_n = tec_pkg::HOLD_NONE;
						phase_n = 1'b0;
						do_match = 1'b1;
					end
				end
				default: begin
					do_match = 1'b1;
				end
			endcase
			if (do_match) begin
				if (pass_q) begin
					emit = 1'b1;
					ob = mb;
					bv = 1'b1;
				end else if (fill_q == '0) begin
					rp_n = '0;
					fill_n = '0;
					pass_n = 1'b1;
					emit = 1'b1;
					ob = mb;
					bv = 1'b1;
				end else if (head == mb) begin
					if (rp_inc == (tec_pkg::AW + 1)'(tec_pkg::ECHO_DEPTH)) begin
						rp_n = '0;
					end else begin
						rp_n = rp_inc[tec_pkg::AW-1:0];
					end
					fill_n = fill_q - 1'b1;
				end else if ((head == tec_pkg::CH_LF) && m_cr) begin
				end else if (m_bs) begin
					if (!ml) begin
						hold_n = tec_pkg::HOLD_BS;
					end
				end else begin
					rp_n = '0;
					fill_n = '0;
					pass_n = 1'b1;
					emit = 1'b1;
					ob = mb;
					bv = 1'b1;
				end
			end
			if (done && e.last) begin
				if (!emit) begin
					emit = 1'b1;
					ob = '0;
					bv = 1'b0;
				end
				ce = 1'b1;
				pass_n = 1'b0;
				hold_n = tec_pkg::HOLD_NONE;
			end
		end
	end

	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign advance = e_valid && (!emit || out_free);
	assign e_pop = advance && done;
	assign rd_addr = advance ? rp_n : rp_q;

	always_ff @(posedge clk) begin
		if (advance && we) begin
			mem[waddr] <= e.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		byp_q <= advance && we && (waddr == rd_addr);
		bypd_q <= e.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			fill_q <= '0;
			pass_q <= 1'b0;
			inrec_q <= 1'b0;
			drop_q <= 1'b0;
			hold_q <= tec_pkg::HOLD_NONE;
			phase_q <= 1'b0;
		end else if (advance) begin
			rp_q <= rp_n;
			fill_q <= fill_n;
			pass_q <= pass_n;
			inrec_q <= inrec_n;
			drop_q <= drop_n;
			hold_q <= hold_n;
			phase_q <= phase_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && emit) begin
			m_axis_tdata <= ob;
			m_axis_tuser <= bv;
			m_axis_tlast <= ce;
		end
	end

endmodule

`default_nettype wire

// File: sv/terminal_echo_canceller_unit.sv
// ----------------------------------------------------------------------------
// terminal_echo_canceller_unit
// removes terminal echo of sent bytes from the received byte stream
// ----------------------------------------------------------------------------
// Record requests (tuser 0) push sent bytes into a 4096-byte expected-echo
// fifo; receive requests (tuser 1) are matched against its head and passed
// on only when they are not echo. Each request passes through the match
// stage, which holds one fifo head compare and pop with the next head read
// from the fifo memory each cycle that it advances; a receive byte that
// follows a held BS SP pair without completing it stays there while the
// held space is matched first. A two-entry queue behind the input and a
// result register decouple both sides, so a request is taken while a result
// still waits. An accepted request is registered in the input queue, and its
// result is then registered in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_echo_canceller_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // data_byte[7:0], chunk_length[23:8]
	input  wire logic s_axis_tuser,         // mode
	input  wire logic s_axis_tlast,         // last_in_chunk
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [7:0] m_axis_tdata,        // out_byte
	output logic m_axis_tuser,              // byte_valid
	output logic m_axis_tlast               // chunk_end
);

	logic e_valid;
	logic e_pop;
	tec_pkg::entry_t e;

	tec_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.e_valid(e_valid),
		.e(e),
		.e_pop(e_pop)
	);

	tec_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.e_valid(e_valid),
		.e(e),
		.e_pop(e_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

endmodule

`default_nettype wire

// File: sv/tec_checker.sv
// ----------------------------------------------------------------------------
// tec_port_checker
// port-level checks of the terminal echo canceller, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tec_port_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	input  wire logic [7:0] m_axis_tdata,
	input  wire logic m_axis_tuser,
	input  wire logic m_axis_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
		else $error("end marker without chunk end");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == 8'h00))
		else $error("end marker carries a byte");

endmodule

bind terminal_echo_canceller_unit tec_port_checker u_tec_port_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser),
	.m_axis_tlast(m_axis_tlast)
);

`default_nettype wire
